// ===== sv/efra_pkg.sv =====
`default_nettype none

package efra_pkg;

  localparam int unsigned MAX_ROOMS_DEF = 1024;
  localparam int unsigned DAY_W         = 32;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned NUM_W         = 11;
  localparam int unsigned IN_TDATA_W    = 2 * DAY_W + TAG_W;
  localparam int unsigned OUT_FIELDS_W  = TAG_W + 2 * NUM_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic out_load;
  } efra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_new;
    logic is_full;
    logic up_root;
    logic up_less;
    logic dn_leaf;
    logic dn_less;
    logic out_free;
  } efra_sts_t;

endpackage

`default_nettype wire

// ===== sv/earliest_free_room_allocator.sv =====
`default_nettype none

// Earliest-free room allocator.
// Input beats on in_* carry a booking request (arrival day, departure day,
// guest tag), expected in ascending arrival order. Each request yields one
// output beat on out_* with the tag, the room given and the number of rooms
// opened; out_tuser flags that a new room was needed but all are in use.
// Rooms sit in a min-heap ordered by (free day, room) held in a two-read,
// one-write RAM; the heap top is also kept in a register.
// A request runs in steps: take the beat, per heap level the entry moves a
// RAM read and then a compare and write, then settle it, then load the output
// register. With MAX_ROOMS = 1024 an entry moves at most 10 levels, and a
// full flag skips the sift. One request is in flight at a time; the next
// beat is taken in the cycle after the result moves to the output register.
// Reset: one room (room 1, free from day 0) is in the heap, no beat pending.
// A stalled receiver holds the result in the output register; the next
// request's result then waits in the controller until the register frees.

module earliest_free_room_allocator
  import efra_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = MAX_ROOMS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // arrival_day[31:0], departure_day[63:32], guest_tag[79:64]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tag_echo[15:0], room_number[26:16], rooms_opened[37:27], zero pad
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // full_error[0]
  output logic                        out_tuser
);

  efra_cmd_t cmd;
  efra_sts_t sts;

  efra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efra_dp #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== sv/efra_ram.sv =====
`default_nettype none

module efra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] ra_data_r;
  logic [WIDTH-1:0] rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data_r <= mem_r[ra_addr];
    rb_data_r <= mem_r[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

`default_nettype wire

// ===== sv/efra_ctrl.sv =====
`default_nettype none

module efra_ctrl
  import efra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire efra_sts_t sts,
  output efra_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_RD  = 6'b000010,
    S_UP_CMP = 6'b000100,
    S_DN_RD  = 6'b001000,
    S_DN_CMP = 6'b010000,
    S_DONE   = 6'b100000
  } efra_state_t;

  efra_state_t state_r;
  efra_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.need_new && sts.is_full) begin
            state_nxt = S_DONE;
          end else if (sts.need_new) begin
            state_nxt = S_UP_RD;
          end else begin
            state_nxt = S_DN_RD;
          end
        end
      end
      S_UP_RD: begin
        cmd.up_rd = 1'b1;
        state_nxt = sts.up_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt  = sts.up_less ? S_UP_RD : S_DONE;
      end
      S_DN_RD: begin
        cmd.dn_rd = 1'b1;
        state_nxt = sts.dn_leaf ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_nxt  = sts.dn_less ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output register busy");

  a_up_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_CMP) |-> ($past(state_r) == S_UP_RD))
    else $error("parent compare without a parent read");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

endmodule

`default_nettype wire

// ===== sv/efra_dp.sv =====
`default_nettype none

module efra_dp
  import efra_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = MAX_ROOMS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tuser,
  input  wire efra_cmd_t              cmd,
  output efra_sts_t                   sts
);

  localparam int unsigned IDX_W = $clog2(MAX_ROOMS);
  localparam int unsigned CNT_W = $clog2(MAX_ROOMS + 1);
  localparam int unsigned KEY_W = DAY_W + CNT_W;
  localparam int unsigned L_W   = CNT_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  logic [DAY_W-1:0] arrival;
  logic [DAY_W-1:0] departure;
  logic [TAG_W-1:0] tag;

  assign arrival   = in_tdata[DAY_W-1:0];
  assign departure = in_tdata[2*DAY_W-1:DAY_W];
  assign tag       = in_tdata[2*DAY_W+TAG_W-1:2*DAY_W];

  // heap entry key: {free day, room}, compared as one unsigned number
  logic [KEY_W-1:0]       top_key_r,  top_key_nxt;
  logic [CNT_W-1:0]       count_r,    count_nxt;
  logic [KEY_W-1:0]       cur_key_r,  cur_key_nxt;
  logic [IDX_W-1:0]       idx_r,      idx_nxt;
  logic [TAG_W-1:0]       tag_r,      tag_nxt;
  logic [CNT_W-1:0]       room_r,     room_nxt;
  logic                   full_r,     full_nxt;
  logic                   rd_zero_r,  rd_zero_nxt;
  logic                   right_ok_r, right_ok_nxt;
  logic [IDX_W-1:0]       lidx_r,     lidx_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r,  out_tdata_nxt;
  logic                   out_tuser_r,  out_tuser_nxt;

  logic [IDX_W-1:0] parent_idx;
  logic [L_W-1:0]   l_full;
  logic [L_W-1:0]   r_full;
  logic             right_ok;
  logic [KEY_W-1:0] ra_data;
  logic [KEY_W-1:0] rb_data;
  logic [KEY_W-1:0] par_key;
  logic             pick_right;
  logic [KEY_W-1:0] s_key;
  logic [IDX_W-1:0] s_idx;
  logic             we;
  logic [KEY_W-1:0] wdata;
  logic [IDX_W-1:0] ra_addr;

  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;
  assign l_full     = (L_W'(idx_r) << 1) + L_W'(1);
  assign r_full     = l_full + L_W'(1);
  assign right_ok   = r_full < L_W'(count_r);

  // entry 0 lives in top_key_r; the RAM copy is never trusted
  assign par_key    = rd_zero_r ? top_key_r : ra_data;
  assign pick_right = right_ok_r && (rb_data < ra_data);
  assign s_key      = pick_right ? rb_data : ra_data;
  assign s_idx      = pick_right ? (lidx_r + IDX_W'(1)) : lidx_r;

  assign sts.need_new = arrival <= top_key_r[KEY_W-1:CNT_W];
  assign sts.is_full  = count_r == CNT_W'(MAX_ROOMS);
  assign sts.up_root  = idx_r == '0;
  assign sts.up_less  = cur_key_r < par_key;
  assign sts.dn_leaf  = l_full >= L_W'(count_r);
  assign sts.dn_less  = s_key < cur_key_r;
  assign sts.out_free = !out_tvalid_r || out_tready;

  // every heap write lands at the hole index
  assign we = (cmd.up_rd && sts.up_root) || cmd.up_cmp ||
              (cmd.dn_rd && sts.dn_leaf) || cmd.dn_cmp;

  always_comb begin
    if (cmd.up_cmp && sts.up_less) begin
      wdata = par_key;
    end else if (cmd.dn_cmp && sts.dn_less) begin
      wdata = s_key;
    end else begin
      wdata = cur_key_r;
    end
  end

  assign ra_addr = cmd.dn_rd ? l_full[IDX_W-1:0] : parent_idx;

  efra_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ROOMS)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (idx_r),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (r_full[IDX_W-1:0]),
    .rb_data (rb_data)
  );

  always_comb begin
    top_key_nxt    = top_key_r;
    count_nxt      = count_r;
    cur_key_nxt    = cur_key_r;
    idx_nxt        = idx_r;
    tag_nxt        = tag_r;
    room_nxt       = room_r;
    full_nxt       = full_r;
    rd_zero_nxt    = rd_zero_r;
    right_ok_nxt   = right_ok_r;
    lidx_nxt       = lidx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (we && idx_r == '0) begin
      top_key_nxt = wdata;
    end

    if (cmd.load) begin
      tag_nxt = tag;
      if (sts.need_new && sts.is_full) begin
        room_nxt = '0;
        full_nxt = 1'b1;
      end else if (sts.need_new) begin
        room_nxt    = count_r + CNT_W'(1);
        count_nxt   = count_r + CNT_W'(1);
        cur_key_nxt = {departure, count_r + CNT_W'(1)};
        idx_nxt     = count_r[IDX_W-1:0];
        full_nxt    = 1'b0;
      end else begin
        room_nxt    = top_key_r[CNT_W-1:0];
        cur_key_nxt = {departure, top_key_r[CNT_W-1:0]};
        idx_nxt     = '0;
        full_nxt    = 1'b0;
      end
    end

    if (cmd.up_rd) begin
      rd_zero_nxt = parent_idx == '0;
    end
    if (cmd.up_cmp && sts.up_less) begin
      idx_nxt = parent_idx;
    end
    if (cmd.dn_rd) begin
      lidx_nxt     = l_full[IDX_W-1:0];
      right_ok_nxt = right_ok;
    end
    if (cmd.dn_cmp && sts.dn_less) begin
      idx_nxt = s_idx;
    end

    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{PAD_W{1'b0}}, NUM_W'(count_r), NUM_W'(room_r), tag_r};
      out_tuser_nxt  = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_key_r    <= {{DAY_W{1'b0}}, CNT_W'(1)};
      count_r      <= CNT_W'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      top_key_r    <= top_key_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_key_r   <= cur_key_nxt;
    idx_r       <= idx_nxt;
    tag_r       <= tag_nxt;
    room_r      <= room_nxt;
    full_r      <= full_nxt;
    rd_zero_r   <= rd_zero_nxt;
    right_ok_r  <= right_ok_nxt;
    lidx_r      <= lidx_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(MAX_ROOMS)))
    else $error("room count out of range");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.need_new && !sts.is_full) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("opened room not counted");

  a_full_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> (out_tdata_r[TAG_W+NUM_W-1:TAG_W] == '0))
    else $error("full beat carries a room");

endmodule

`default_nettype wire

// ===== bench/tb_earliest_free_room_allocator.sv =====
`default_nettype none

module tb_earliest_free_room_allocator
  import efra_pkg::*;
();

  localparam int unsigned ROOMS       = MAX_ROOMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN       = 30;

  // packed so that arrival lands in the lowest bits of in_tdata
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [DAY_W-1:0] departure;
    logic [DAY_W-1:0] arrival;
  } booking_t;

  typedef struct packed {
    logic             full;
    logic [NUM_W-1:0] opened;
    logic [NUM_W-1:0] room;
    logic [TAG_W-1:0] tag;
  } allocation_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  earliest_free_room_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // room heap mirror, ordered by (free day, room)
  logic [DAY_W-1:0] free_day [ROOMS];
  logic [NUM_W-1:0] room_id  [ROOMS];
  int unsigned      rooms_in_use;

  booking_t    pending_bookings [$];
  allocation_t expected_alloc   [$];

  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait = 0;
  int unsigned hold_left = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  function automatic bit precedes(int unsigned a, int unsigned b);
    if (free_day[a] != free_day[b])
      return free_day[a] < free_day[b];
    return room_id[a] < room_id[b];
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [DAY_W-1:0] d;
    logic [NUM_W-1:0] r;
    d = free_day[a];
    r = room_id[a];
    free_day[a] = free_day[b];
    room_id[a]  = room_id[b];
    free_day[b] = d;
    room_id[b]  = r;
  endfunction

  function automatic void raise_entry(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!precedes(i, p))
        break;
      swap_entries(i, p);
      i = p;
    end
  endfunction

  function automatic void lower_entry(int unsigned i);
    int unsigned l;
    int unsigned s;
    forever begin
      l = 2 * i + 1;
      if (l >= rooms_in_use)
        break;
      s = l;
      if (l + 1 < rooms_in_use && precedes(l + 1, l))
        s = l + 1;
      if (!precedes(s, i))
        break;
      swap_entries(s, i);
      i = s;
    end
  endfunction

  function automatic allocation_t assign_room(booking_t b);
    allocation_t res;
    int unsigned slot;
    res.tag  = b.tag;
    res.room = '0;
    res.full = 1'b0;
    if (b.arrival <= free_day[0]) begin
      if (rooms_in_use >= ROOMS) begin
        res.full = 1'b1;
      end else begin
        slot = rooms_in_use;
        free_day[slot] = b.departure;
        room_id[slot]  = NUM_W'(rooms_in_use + 1);
        res.room       = NUM_W'(rooms_in_use + 1);
        rooms_in_use++;
        raise_entry(slot);
      end
    end else begin
      res.room    = room_id[0];
      free_day[0] = b.departure;
      lower_entry(0);
    end
    res.opened = NUM_W'(rooms_in_use);
    return res;
  endfunction

  // mostly short gaps, a few long ones, none in a calm stretch
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic book(input logic [DAY_W-1:0] arrival, input logic [DAY_W-1:0] departure,
                      input logic [TAG_W-1:0] tag);
    booking_t b;
    b.arrival   = arrival;
    b.departure = departure;
    b.tag       = tag;
    pending_bookings.insert(pending_bookings.size(), b);
  endtask

  function automatic logic [TAG_W-1:0] any_tag();
    return TAG_W'($urandom_range(0, 65535));
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0)
      calm_in <= !calm_in;
    if ($urandom_range(0, 299) == 0)
      calm_out <= !calm_out;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid)
        expected_alloc.insert(expected_alloc.size(), assign_room(booking_t'(in_tdata)));
      if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_bookings.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_bookings.pop_front();
        send_wait <= pick_gap(calm_in);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic report_fault(input string what);
    if (fault_count < 10)
      $display("%s", what);
    fault_count++;
  endtask

  // result monitor
  always @(posedge clk) begin : monitor
    allocation_t seen;
    allocation_t want;
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else begin
      stall = hold_left;
      if (out_tvalid && out_tready) begin
        seen.tag    = out_tdata[0 +: TAG_W];
        seen.room   = out_tdata[TAG_W +: NUM_W];
        seen.opened = out_tdata[TAG_W + NUM_W +: NUM_W];
        seen.full   = out_tuser;
        if (expected_alloc.size() == 0) begin
          report_fault($sformatf("unexpected beat: tag %h room %0d opened %0d full %0b",
                                 seen.tag, seen.room, seen.opened, seen.full));
        end else begin
          want = expected_alloc.pop_front();
          if (seen.tag !== want.tag || seen.room !== want.room ||
              seen.opened !== want.opened || seen.full !== want.full)
            report_fault($sformatf(
              "mismatch (tag room opened full): expected %h %0d %0d %0b, got %h %0d %0d %0b",
              want.tag, want.room, want.opened, want.full,
              seen.tag, seen.room, seen.opened, seen.full));
        end
        stall = pick_gap(calm_out);
      end else if (stall == 0 && !calm_out && $urandom_range(0, 15) == 0) begin
        // stall at an arbitrary point of the sift, not only right after a beat
        stall = $urandom_range(1, 30);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        hold_left  <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        hold_left  <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DAY_W-1:0] cursor;
    logic [DAY_W-1:0] arrival;
    int unsigned      r;

    free_day[0]  = '0;
    room_id[0]   = NUM_W'(1);
    rooms_in_use = 1;

    // arrival on the free day of room 1 opens room 2
    book(32'd0, 32'd5, 16'h0000);
    book(32'd1, 32'd3, 16'hFFFF);
    // arrival equal to the top free day, tie broken by room number later
    book(32'd3, 32'd3, 16'h0001);
    book(32'd4, 32'd10, 16'h8000);
    // departure before arrival
    book(32'd4, 32'd2, 16'h7FFF);
    // out of order
    book(32'd3, 32'd7, 16'h5555);
    book(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA);
    book(32'hFFFF_FFFF, 32'd0, 16'h1234);
    book(32'd0, 32'hFFFF_FFFF, 16'hFEDC);
    book(32'd0, 32'd0, 16'h0F0F);
    book(32'd0, 32'd0, 16'hF0F0);
    book(32'd1, 32'd0, 16'h00FF);
    book(32'hAAAA_AAAA, 32'h5555_5555, 16'hFF00);
    book(32'h5555_5555, 32'hAAAA_AAAA, 16'h3C3C);
    book(32'h8000_0000, 32'h7FFF_FFFF, 16'hC3C3);
    book(32'h7FFF_FFFF, 32'h8000_0000, 16'h0002);
    book(32'd2, 32'd2, 16'hFFFE);
    book(32'd3, 32'hFFFF_FFFE, 16'h4000);

    // ascending bookings with short stays, some out of order, some noise
    cursor = '0;
    repeat (300) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        book($urandom, $urandom, any_tag());
      end else if (r == 1) begin
        arrival = cursor - $urandom_range(0, 20);
        book(arrival, arrival + $urandom_range(0, 30), any_tag());
      end else begin
        cursor = cursor + $urandom_range(0, 3);
        book(cursor, cursor + $urandom_range(0, 40), any_tag());
      end
    end

    // arrival 0 always needs a new room: grow the heap several levels deep
    repeat (100) begin
      if ($urandom_range(0, 1) == 0)
        book(32'd0, $urandom, any_tag());
      else
        book(32'd0, $urandom_range(0, 5000), any_tag());
    end

    // deep heap: long reuse sifts mixed with further new rooms
    repeat (30) begin
      r = $urandom_range(0, 3);
      if (r == 0)
        book(32'd0, $urandom, any_tag());
      else if (r == 3)
        book($urandom, $urandom_range(0, 1000), any_tag());
      else
        book($urandom, $urandom, any_tag());
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bookings.size() != 0 || in_tvalid || expected_alloc.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
